// File: hdl/rpg_pkg.sv
// ----------------------------------------------------------------------------
// rpg_pkg - shared types, constants and microprogram of the permutation block
// Holds the field widths, the xorshift step, the control word layout and the
// read-only program that sequences fill, shuffle and output.
// ----------------------------------------------------------------------------
package rpg_pkg;

	// Field widths and generator constants
	localparam int COUNT_W       = 5;
	localparam int VALUE_W       = 4;
	localparam int GEN_W         = 64;
	localparam int DRAW_W        = 32;
	localparam int DRAW_LSB      = 11;
	localparam int XS_A          = 13;
	localparam int XS_B          = 7;
	localparam int XS_C          = 17;
	localparam int DEF_MAX_COUNT = 16;
	localparam logic [GEN_W-1:0] RESET_SEED = 64'd88172645463325252;

	// Modulo unit: draw bits retired per cycle and cycles per draw
	localparam int MOD_BITS  = 2;
	localparam int MOD_STEPS = DRAW_W / MOD_BITS;
	localparam int MCNT_W    = $clog2(MOD_STEPS);

	// Microprogram addressing
	localparam int STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t ST_IDLE   = 4'd0;
	localparam step_t ST_FILL   = 4'd1;
	localparam step_t ST_TOP    = 4'd2;
	localparam step_t ST_GEN    = 4'd3;
	localparam step_t ST_MOD    = 4'd4;
	localparam step_t ST_RDI    = 4'd5;
	localparam step_t ST_RDJ    = 4'd6;
	localparam step_t ST_WRI    = 4'd7;
	localparam step_t ST_WRJ    = 4'd8;
	localparam step_t ST_OUT_RD = 4'd9;
	localparam step_t ST_OUT_LD = 4'd10;

	// Store address source
	typedef enum logic [1:0] {
		ADR_K = 2'd0,
		ADR_I = 2'd1,
		ADR_J = 2'd2
	} addr_sel_t;

	// Store write data source
	typedef enum logic [1:0] {
		WD_K    = 2'd0,
		WD_RD   = 2'd1,
		WD_HOLD = 2'd2
	} wdata_sel_t;

	// Register update performed by a step
	typedef enum logic [2:0] {
		OP_NONE    = 3'd0,
		OP_ACCEPT  = 3'd1,
		OP_KINC    = 3'd2,
		OP_SET_TOP = 3'd3,
		OP_GEN     = 3'd4,
		OP_MOD     = 3'd5,
		OP_TAKE_VI = 3'd6,
		OP_EMIT    = 3'd7
	} op_t;

	// Jump condition tested at the end of a step: true takes tgt_t
	typedef enum logic [2:0] {
		CND_NEVER      = 3'd0,
		CND_NO_START   = 3'd1,
		CND_K_NOT_LAST = 3'd2,
		CND_N_ONE      = 3'd3,
		CND_MOD_MORE   = 3'd4,
		CND_I_NOT_ONE  = 3'd5,
		CND_OUT_BUSY   = 3'd6
	} cond_t;

	typedef struct packed {
		logic       we;
		logic       idec;
		addr_sel_t  addr;
		wdata_sel_t wsel;
		op_t        op;
		cond_t      cond;
		step_t      tgt_t;
		step_t      tgt_f;
	} uword_t;

	// Program ROM: one control word per step
	function automatic uword_t ucode(step_t pc);
		uword_t w;
		w = '{we: 1'b0, idec: 1'b0, addr: ADR_K, wsel: WD_K, op: OP_NONE,
		      cond: CND_NEVER, tgt_t: ST_IDLE, tgt_f: ST_IDLE};
		case (pc)
			ST_IDLE: begin
				w.op = OP_ACCEPT; w.cond = CND_NO_START;
				w.tgt_t = ST_IDLE; w.tgt_f = ST_FILL;
			end
			ST_FILL: begin
				w.we = 1'b1; w.addr = ADR_K; w.wsel = WD_K; w.op = OP_KINC;
				w.cond = CND_K_NOT_LAST; w.tgt_t = ST_FILL; w.tgt_f = ST_TOP;
			end
			ST_TOP: begin
				w.op = OP_SET_TOP; w.cond = CND_N_ONE;
				w.tgt_t = ST_OUT_RD; w.tgt_f = ST_GEN;
			end
			ST_GEN: begin
				w.op = OP_GEN; w.tgt_f = ST_MOD;
			end
			ST_MOD: begin
				w.op = OP_MOD; w.cond = CND_MOD_MORE;
				w.tgt_t = ST_MOD; w.tgt_f = ST_RDI;
			end
			ST_RDI: begin
				w.addr = ADR_I; w.tgt_f = ST_RDJ;
			end
			ST_RDJ: begin
				w.addr = ADR_J; w.op = OP_TAKE_VI; w.tgt_f = ST_WRI;
			end
			ST_WRI: begin
				w.we = 1'b1; w.addr = ADR_I; w.wsel = WD_RD; w.tgt_f = ST_WRJ;
			end
			ST_WRJ: begin
				w.we = 1'b1; w.addr = ADR_J; w.wsel = WD_HOLD; w.idec = 1'b1;
				w.cond = CND_I_NOT_ONE; w.tgt_t = ST_GEN; w.tgt_f = ST_OUT_RD;
			end
			ST_OUT_RD: begin
				w.addr = ADR_K; w.cond = CND_OUT_BUSY;
				w.tgt_t = ST_OUT_RD; w.tgt_f = ST_OUT_LD;
			end
			ST_OUT_LD: begin
				w.op = OP_EMIT; w.cond = CND_K_NOT_LAST;
				w.tgt_t = ST_OUT_RD; w.tgt_f = ST_IDLE;
			end
			default: begin
				w.tgt_f = ST_IDLE;
			end
		endcase
		return w;
	endfunction

	// One xorshift64 step (13, 7, 17)
	function automatic logic [GEN_W-1:0] xs_next(logic [GEN_W-1:0] s);
		logic [GEN_W-1:0] t;
		t = s ^ (s << XS_A);
		t = t ^ (t >> XS_B);
		t = t ^ (t << XS_C);
		return t;
	endfunction

endpackage

// File: hdl/random_permutation_generator.sv
// ----------------------------------------------------------------------------
// random_permutation_generator - Fisher-Yates shuffle with xorshift64 draws
// Sequenced by a small microprogram over a counter/modulo datapath and a
// single-port permutation store.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / count): one transfer per request.
//   count is saturated to MAX_COUNT; a count of zero yields no output.
//   Output channel (out_valid / out_stall / value / last): count transfers,
//   the shuffled indices in store order, last high on the final one.
//   seed_we / seed_data load the 64-bit generator state directly; write only
//   while the block is idle. The generator state carries over between
//   requests.
// Sequence for a count n >= 2:
//   accept, fill of n entries, setup, one shuffle step for each i from n-1
//   down to 1, then a read and a load of the output register per index. Each
//   shuffle step is one xorshift step, a modulo pass (two draw bits per cycle)
//   and a swap through the one store port: read i, read j, write i, write j.
//   in_stall stays high from acceptance until the last result is loaded into
//   the output register, so the next request can be taken while that result
//   waits. A stalled output holds its register and the sequencer waits.
// Reset: sequencer returns to idle, output register empties, generator is
//   loaded with the reset seed. The store needs no clearing.
// ----------------------------------------------------------------------------
module random_permutation_generator #(
	parameter int MAX_COUNT = rpg_pkg::DEF_MAX_COUNT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        seed_we,
	input  logic [rpg_pkg::GEN_W-1:0]   seed_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [rpg_pkg::COUNT_W-1:0] count,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [rpg_pkg::VALUE_W-1:0] value,
	output logic                        last
);

	import rpg_pkg::*;

	localparam int IW = $clog2(MAX_COUNT);
	localparam int CW = $clog2(MAX_COUNT + 1);
	localparam int LW = (CW > COUNT_W) ? CW : COUNT_W;
	localparam int EW = (IW > VALUE_W) ? IW : VALUE_W;

	step_t            upc_q;
	uword_t           uw;
	logic             cond_hit;
	logic [CW-1:0]    n_q;
	logic [CW-1:0]    n_sat;
	logic [LW-1:0]    cnt_ext;
	logic [IW-1:0]    k_q;
	logic [IW-1:0]    i_q;
	logic [IW-1:0]    rem_q;
	logic [IW-1:0]    rem_nx;
	logic [IW:0]      divisor;
	logic [DRAW_W-1:0] draw_q;
	logic [MCNT_W-1:0] mcnt_q;
	logic [GEN_W-1:0] gen_q;
	logic [GEN_W-1:0] gen_nx;
	logic [IW-1:0]    vi_q;
	logic [IW-1:0]    mem_addr;
	logic [IW-1:0]    mem_wdata;
	logic [IW-1:0]    mem_rdata;
	logic [EW-1:0]    elem_ext;
	logic             in_xfer;
	logic             out_xfer;
	logic             k_last;
	logic             out_valid_q;
	logic [VALUE_W-1:0] value_q;
	logic             last_q;

	// Fetch the control word of the current step
	assign uw = ucode(upc_q);

	// Saturate the requested count
	assign cnt_ext = LW'(count);
	assign n_sat   = (cnt_ext > LW'(MAX_COUNT)) ? CW'(MAX_COUNT) : CW'(cnt_ext);

	assign in_stall = (upc_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;
	assign k_last   = (CW'(k_q) == n_q - CW'(1));

	// Evaluate the jump condition
	always_comb begin
		case (uw.cond)
			CND_NEVER:      cond_hit = 1'b0;
			CND_NO_START:   cond_hit = !(in_xfer && (n_sat != '0));
			CND_K_NOT_LAST: cond_hit = !k_last;
			CND_N_ONE:      cond_hit = (n_q == CW'(1));
			CND_MOD_MORE:   cond_hit = (mcnt_q != MCNT_W'(MOD_STEPS - 1));
			CND_I_NOT_ONE:  cond_hit = (i_q != IW'(1));
			CND_OUT_BUSY:   cond_hit = out_valid_q && out_stall;
			default:        cond_hit = 1'b0;
		endcase
	end

	// Advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= ST_IDLE;
		end else begin
			upc_q <= cond_hit ? uw.tgt_t : uw.tgt_f;
		end
	end

	// Retire two draw bits per cycle: restoring remainder against i+1
	assign divisor = (IW + 1)'(i_q) + (IW + 1)'(1);
	always_comb begin
		logic [IW:0] r;
		r = {1'b0, rem_q};
		for (int b = 0; b < MOD_BITS; b++) begin
			r = {r[IW-1:0], draw_q[DRAW_W-1-b]};
			if (r >= divisor) begin
				r = r - divisor;
			end
		end
		rem_nx = r[IW-1:0];
	end

	assign gen_nx = xs_next(gen_q);

	// Generator state: seed load or one step per draw
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= RESET_SEED;
		end else if (seed_we) begin
			gen_q <= seed_data;
		end else if (uw.op == OP_GEN) begin
			gen_q <= gen_nx;
		end
	end

	// Datapath registers driven by the control word
	always_ff @(posedge clk) begin
		case (uw.op)
			OP_ACCEPT: begin
				n_q <= n_sat;
				k_q <= '0;
			end
			OP_KINC: begin
				k_q <= k_q + IW'(1);
			end
			OP_SET_TOP: begin
				i_q <= IW'(n_q - CW'(1));
				k_q <= '0;
			end
			OP_GEN: begin
				draw_q <= gen_nx[DRAW_LSB +: DRAW_W];
				rem_q  <= '0;
				mcnt_q <= '0;
			end
			OP_MOD: begin
				draw_q <= draw_q << MOD_BITS;
				rem_q  <= rem_nx;
				mcnt_q <= mcnt_q + MCNT_W'(1);
			end
			OP_TAKE_VI: begin
				vi_q <= mem_rdata;
			end
			OP_EMIT: begin
				k_q <= k_q + IW'(1);
			end
			default: begin
			end
		endcase
		if (uw.idec) begin
			i_q <= i_q - IW'(1);
			k_q <= '0;
		end
	end

	// Select store address and write data
	always_comb begin
		case (uw.addr)
			ADR_K:   mem_addr = k_q;
			ADR_I:   mem_addr = i_q;
			ADR_J:   mem_addr = rem_q;
			default: mem_addr = k_q;
		endcase
		case (uw.wsel)
			WD_K:    mem_wdata = k_q;
			WD_RD:   mem_wdata = mem_rdata;
			WD_HOLD: mem_wdata = vi_q;
			default: mem_wdata = k_q;
		endcase
	end

	rpg_ram #(
		.WIDTH (IW),
		.DEPTH (MAX_COUNT)
	) u_store (
		.clk   (clk),
		.we    (uw.we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// Output register: load on emit, drop on transfer
	assign elem_ext = EW'(mem_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (uw.op == OP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uw.op == OP_EMIT) begin
			value_q <= elem_ext[VALUE_W-1:0];
			last_q  <= k_last;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign last      = last_q;

endmodule

// File: hdl/rpg_ram.sv
// ----------------------------------------------------------------------------
// rpg_ram - generic single-port RAM
// One write or read address per cycle, read data registered.
// ----------------------------------------------------------------------------
module rpg_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read at the same address
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
